### sv/twqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twqs_pkg;

    localparam int NUM_CLS = 3;

    localparam logic [1:0] CLS_NORMAL   = 2'd0;
    localparam logic [1:0] CLS_PRIORITY = 2'd1;
    localparam logic [1:0] CLS_URGENT   = 2'd2;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_SERVE   = 1'b1;

    localparam int          BURST_W         = 8;
    localparam logic [7:0]  NORMAL_BURST_RST = 8'd2;

    // word index of the normal_burst register
    localparam logic        REG_NORMAL_BURST = 1'b0;

    typedef struct packed {
        logic [7:0]  age;
        logic [15:0] ticket_id;
        logic [15:0] patient_id;
    } twqs_entry_t;

    typedef struct packed {
        logic [NUM_CLS-1:0] push;
        logic [NUM_CLS-1:0] pop;
        logic               served;
        logic [1:0]         served_class;
        logic               dropped;
    } twqs_ctl_t;

endpackage

`default_nettype wire

### sv/twqs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module twqs_fifo
    import twqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        pop,
    input  wire twqs_entry_t wr_entry,
    output twqs_entry_t      rd_entry,
    output logic             empty,
    output logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    twqs_entry_t store_mem [DEPTH];
    twqs_entry_t rd_entry_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // read data is registered and held until the next pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_mem[tail_reg] <= wr_entry;
        end
        if (pop)
        begin
            rd_entry_reg <= store_mem[head_reg];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

### sv/twqs_sched.sv
`timescale 1ns / 1ps
`default_nettype none

module twqs_sched
    import twqs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic               req_type,
    input  wire logic [1:0]         queue_class,
    input  wire logic [NUM_CLS-1:0] empty,
    input  wire logic [NUM_CLS-1:0] full,
    input  wire logic [7:0]         normal_burst,
    output twqs_ctl_t               ctl
);

    logic [BURST_W-1:0] burst_reg, burst_next;

    always_comb
    begin
        ctl        = '0;
        burst_next = burst_reg;
        if (go)
        begin
            if (req_type == REQ_ENQUEUE)
            begin
                case (queue_class)
                    CLS_NORMAL, CLS_PRIORITY, CLS_URGENT:
                    begin
                        if (full[queue_class])
                        begin
                            ctl.dropped = 1'b1;
                        end
                        else
                        begin
                            ctl.push[queue_class] = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.dropped = 1'b1;
                    end
                endcase
            end
            else
            begin
                // urgent first, then normal within its burst, then priority, then normal past its burst
                if (!empty[CLS_URGENT])
                begin
                    ctl.served       = 1'b1;
                    ctl.served_class = CLS_URGENT;
                end
                else if ((burst_reg < normal_burst) && !empty[CLS_NORMAL])
                begin
                    ctl.served       = 1'b1;
                    ctl.served_class = CLS_NORMAL;
                    burst_next       = burst_reg + BURST_W'(1);
                end
                else if (!empty[CLS_PRIORITY])
                begin
                    ctl.served       = 1'b1;
                    ctl.served_class = CLS_PRIORITY;
                    burst_next       = '0;
                end
                else if (!empty[CLS_NORMAL])
                begin
                    ctl.served       = 1'b1;
                    ctl.served_class = CLS_NORMAL;
                    burst_next       = BURST_W'(1);
                end
                if (ctl.served)
                begin
                    ctl.pop[ctl.served_class] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= '0;
        end
        else
        begin
            burst_reg <= burst_next;
        end
    end

endmodule

`default_nettype wire

### sv/three_class_weighted_queue_server_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Content
// s_*       in         s_tvalid / s_tready      request beat: tuser kind+class, tdata entry
// m_*       out        m_tvalid / m_tready      result beat: tuser flags+class, tdata entry
// APB       in/out     psel, penable / pready   normal_burst at word 0
//
// One beat accepted per cycle unless a stalled m_tready holds the result stage.
// Stage one holds the request and makes the pick; the queue memory read port
// registers the popped entry into the result stage.
// Reset clears pointers, counts, burst count and valid bits; queue contents stay
// undefined. A stalled m_tready holds the result stage and, behind it, s_tready.

module three_class_weighted_queue_server_core
    import twqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // req_type, queue_class[1:0]
    input  wire logic [39:0] s_tdata,   // patient_id, ticket_id, age

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [3:0]       m_tuser,   // served, served_class[1:0], dropped
    output logic [39:0]      m_tdata,   // out_patient_id, out_ticket_id, out_age

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] normal_burst_reg;

    logic        a_valid_reg;
    logic        a_req_reg;
    logic [1:0]  a_cls_reg;
    twqs_entry_t a_entry_reg;
    logic        a_advance;

    logic        b_valid_reg;
    logic        b_served_reg;
    logic [1:0]  b_cls_reg;
    logic        b_dropped_reg;

    twqs_ctl_t          ctl;
    logic [NUM_CLS-1:0] empty;
    logic [NUM_CLS-1:0] full;
    twqs_entry_t        rd_entry [NUM_CLS];
    twqs_entry_t        out_entry;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_burst_reg <= NORMAL_BURST_RST;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_NORMAL_BURST))
        begin
            normal_burst_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_NORMAL_BURST) ? {24'd0, normal_burst_reg} : '0;

    // request stage
    assign a_advance = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_req_reg   <= s_tuser[0];
            a_cls_reg   <= s_tuser[2:1];
            a_entry_reg <= s_tdata;
        end
    end

    twqs_sched u_sched
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (a_advance),
        .req_type     (a_req_reg),
        .queue_class  (a_cls_reg),
        .empty        (empty),
        .full         (full),
        .normal_burst (normal_burst_reg),
        .ctl          (ctl)
    );

    for (genvar c = 0; c < NUM_CLS; c++)
    begin : g_queue
        twqs_fifo #(
            .DEPTH (QUEUE_DEPTH)
        ) u_fifo
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .push     (ctl.push[c]),
            .pop      (ctl.pop[c]),
            .wr_entry (a_entry_reg),
            .rd_entry (rd_entry[c]),
            .empty    (empty[c]),
            .full     (full[c])
        );
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!b_valid_reg || m_tready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            b_served_reg  <= ctl.served;
            b_cls_reg     <= ctl.served_class;
            b_dropped_reg <= ctl.dropped;
        end
    end

    always_comb
    begin
        case (b_cls_reg)
            CLS_NORMAL:   out_entry = rd_entry[CLS_NORMAL];
            CLS_PRIORITY: out_entry = rd_entry[CLS_PRIORITY];
            CLS_URGENT:   out_entry = rd_entry[CLS_URGENT];
            default:      out_entry = '0;
        endcase
    end

    assign m_tvalid = b_valid_reg;
    assign m_tuser  = {b_dropped_reg, b_cls_reg, b_served_reg};
    assign m_tdata  = b_served_reg ? out_entry : '0;

endmodule

`default_nettype wire

### sv/twqs_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module twqs_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [3:0]  m_tuser,
    input wire logic [39:0] m_tdata,
    input wire logic [31:0] prdata
);

    // a beat never both serves and drops
    a_serve_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[3]))
        else $error("result flags served and dropped together");

    // nothing served means an all-zero entry and class
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 40'd0 && m_tuser[2:1] == 2'd0))
        else $error("unserved result carries data");

    // no fourth class is ever served
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] != 2'd3))
        else $error("served class out of range");

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    // register readback is only eight bits wide
    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:8] == 24'd0)
        else $error("readback upper bits set");

endmodule

bind three_class_weighted_queue_server_core twqs_chk u_twqs_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .prdata   (prdata)
);

`default_nettype wire
